// ===== hw/rtl/bba_pkg.sv =====
// Shared types, constants and helper functions of the buddy block allocator.
`timescale 1ns / 1ps

package bba_pkg;

  // Region of 2**LOG_BLOCKS minimum blocks; a link with its top bit set is null.
  localparam int LOG_BLOCKS = 10;
  localparam int NBLK       = 1 << LOG_BLOCKS;
  localparam int AW         = LOG_BLOCKS;
  localparam int LW         = AW + 1;
  localparam int OW         = 4;
  localparam int NLISTS     = LOG_BLOCKS + 1;

  typedef logic [AW-1:0] blk_t;
  typedef logic [LW-1:0] link_t;
  typedef logic [OW-1:0] ord_t;

  localparam link_t NIL     = link_t'(NBLK);
  localparam ord_t  ORD_TOP = ord_t'(LOG_BLOCKS);
  localparam link_t NBLK_L  = link_t'(NBLK);

  // One word of the block store.
  typedef struct packed {
    logic  avail;
    ord_t  ord;
    link_t nxt;
    link_t prv;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{avail: 1'b0, ord: '0, nxt: NIL, prv: NIL};

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_SEED  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Configuration register indexes.
  localparam logic REG_MAX_LEVEL = 1'b0;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_F_RD,
    ST_F_CHK,
    ST_M_TEST,
    ST_M_BQ,
    ST_UNL,
    ST_UNL2,
    ST_M_UPD,
    ST_PUSH,
    ST_F_DONE,
    ST_A_RD,
    ST_A_Q,
    ST_SPLIT,
    ST_P_RD,
    ST_P_WR
  } state_t;

  // A link names a real block when its top bit is clear.
  function automatic logic link_ok(input link_t l);
    return !l[LW-1];
  endfunction

  function automatic logic is_pow2(input link_t v);
    return (v != '0) && ((v & (v - link_t'(1))) == '0);
  endfunction

  // Position of the highest set bit.
  function automatic ord_t log2_of(input link_t v);
    ord_t r;
    r = '0;
    for (int b = 0; b < LW; b++) begin
      if (v[b]) begin
        r = ord_t'(b);
      end
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/buddy_block_allocator.sv =====
// Buddy block allocator: control sequencer, free-list heads and block store.
`timescale 1ns / 1ps

// A command is taken when start is high and busy is low; its single result
// appears on the out_ ports for exactly one cycle with out_valid, and must be
// captured then. All per-block state (free flag, order and both list links)
// sits in one 1024-word synchronous memory, so each step of a request reads a
// word, registers it and writes a word back. After reset the block clears that
// memory, one word a cycle, with busy high; configuration writes are taken
// during that time. A rejected command is answered from the idle state. An
// allocation reads the head block of its list, relinks that block's successor
// when it has one, and then splits down level by level. A free or seed of a
// block that is already free is refused; otherwise the block merges with a
// free buddy at each level it can, up to all ten levels, and is then pushed.
module buddy_block_allocator import bba_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [9:0]  in_block_offset,
  input  logic [10:0] in_request_size,
  output logic        out_valid,
  output logic        out_ok,
  output logic [9:0]  out_granted_block,
  output logic [10:0] out_free_count,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Block store.
  entry_t mem [NBLK];
  entry_t mem_q_r;
  logic   mem_we;
  blk_t   mem_waddr;
  entry_t mem_wdata;
  blk_t   mem_raddr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q_r <= mem[mem_raddr];
  end

  // Control and datapath registers.
  state_t state_r, state_nxt;
  blk_t   clr_r, clr_nxt;
  link_t  head_r [NLISTS];
  logic   head_we;
  ord_t   head_idx;
  link_t  head_val;
  ord_t   max_level_r;
  link_t  free_r, free_nxt;
  op_t    op_r, op_nxt;
  link_t  sz_r, sz_nxt;
  blk_t   i_r, i_nxt;
  blk_t   b_r, b_nxt;
  ord_t   k_r, k_nxt;
  ord_t   j_r, j_nxt;
  ord_t   kn_r, kn_nxt;
  link_t  p_r, p_nxt;
  link_t  n_r, n_nxt;
  entry_t iw_r, iw_nxt;
  blk_t   pa_r, pa_nxt;
  link_t  pv_r, pv_nxt;
  logic   pn_r, pn_nxt;
  state_t pret_r, pret_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_ok_r, out_ok_nxt;
  blk_t   out_grant_r, out_grant_nxt;
  link_t  out_count_r, out_count_nxt;

  // Shared decode.
  logic   accept;
  ord_t   km;
  link_t  sz_eff;
  ord_t   a_k;
  logic   found;
  ord_t   j_sel;
  logic   alloc_ok;
  logic   seed_ok;
  logic   idle_fail;
  logic   merge_ok;
  logic   buddy_ok;
  blk_t   b_calc;
  link_t  push_h;
  ord_t   jm;
  blk_t   c_calc;
  link_t  split_h;
  logic   fin;
  logic   fin_ok;
  logic   [LW:0] add_sum;
  link_t  cnt_add;
  link_t  cnt_sub;

  assign accept = start && (state_r == ST_IDLE);
  assign km     = (max_level_r > ORD_TOP) ? ORD_TOP : max_level_r;
  assign sz_eff = (in_request_size == '0) ? link_t'(1) : in_request_size;
  assign a_k    = log2_of(sz_eff);

  // Smallest non-empty list at or above the needed order and not above the level cap.
  always_comb begin
    found = 1'b0;
    j_sel = '0;
    for (int j = 0; j < NLISTS; j++) begin
      if (!found && (ord_t'(j) >= a_k) && (ord_t'(j) <= km) && link_ok(head_r[j])) begin
        found = 1'b1;
        j_sel = ord_t'(j);
      end
    end
  end

  assign alloc_ok  = is_pow2(sz_eff) && (a_k <= km) && found;
  assign seed_ok   = is_pow2(in_request_size);
  assign idle_fail = ((op_t'(in_op) == OP_ALLOC) && !alloc_ok) ||
                     ((op_t'(in_op) == OP_SEED) && !seed_ok) ||
                     (op_t'(in_op) == OP_NONE);
  assign merge_ok  = (k_r < km) && (k_r < ORD_TOP);
  assign buddy_ok  = mem_q_r.avail && (mem_q_r.ord == k_r);
  assign b_calc    = i_r ^ (blk_t'(1) << k_r);
  assign push_h    = head_r[k_r];
  assign jm        = j_r - ord_t'(1);
  assign c_calc    = i_r + (blk_t'(1) << jm);
  assign split_h   = head_r[jm];

  // Completion of a command.
  always_comb begin
    fin    = 1'b0;
    fin_ok = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        fin = accept && idle_fail;
      end
      ST_F_CHK: begin
        fin = mem_q_r.avail;
      end
      ST_PUSH: begin
        fin    = !link_ok(push_h);
        fin_ok = 1'b1;
      end
      ST_F_DONE: begin
        fin    = 1'b1;
        fin_ok = 1'b1;
      end
      ST_SPLIT: begin
        fin    = (j_r == kn_r);
        fin_ok = 1'b1;
      end
      default: begin
        fin    = 1'b0;
        fin_ok = 1'b0;
      end
    endcase
  end

  // Saturating free-count updates.
  assign add_sum = {1'b0, free_r} + {1'b0, sz_r};
  assign cnt_add = (add_sum > {1'b0, NBLK_L}) ? NBLK_L : add_sum[LW-1:0];
  assign cnt_sub = (free_r > sz_r) ? (free_r - sz_r) : '0;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && !idle_fail) begin
          state_nxt = (op_t'(in_op) == OP_ALLOC) ? ST_A_RD : ST_F_RD;
        end
      end
      ST_F_RD:   state_nxt = ST_F_CHK;
      ST_F_CHK:  state_nxt = mem_q_r.avail ? ST_IDLE : ST_M_TEST;
      ST_M_TEST: state_nxt = merge_ok ? ST_M_BQ : ST_PUSH;
      ST_M_BQ:   state_nxt = buddy_ok ? ST_UNL : ST_PUSH;
      ST_UNL:    state_nxt = link_ok(p_r) ? ST_P_RD : ST_UNL2;
      ST_UNL2:   state_nxt = link_ok(n_r) ? ST_P_RD : ST_M_UPD;
      ST_M_UPD:  state_nxt = ST_M_TEST;
      ST_PUSH:   state_nxt = link_ok(push_h) ? ST_P_RD : ST_IDLE;
      ST_F_DONE: state_nxt = ST_IDLE;
      ST_A_RD:   state_nxt = ST_A_Q;
      ST_A_Q:    state_nxt = link_ok(mem_q_r.nxt) ? ST_P_RD : ST_SPLIT;
      ST_SPLIT: begin
        if (j_r == kn_r) begin
          state_nxt = ST_IDLE;
        end else if (link_ok(split_h)) begin
          state_nxt = ST_P_RD;
        end
      end
      ST_P_RD:   state_nxt = ST_P_WR;
      ST_P_WR:   state_nxt = pret_r;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Datapath, list heads and memory port.
  always_comb begin
    clr_nxt       = clr_r;
    free_nxt      = free_r;
    op_nxt        = op_r;
    sz_nxt        = sz_r;
    i_nxt         = i_r;
    b_nxt         = b_r;
    k_nxt         = k_r;
    j_nxt         = j_r;
    kn_nxt        = kn_r;
    p_nxt         = p_r;
    n_nxt         = n_r;
    iw_nxt        = iw_r;
    pa_nxt        = pa_r;
    pv_nxt        = pv_r;
    pn_nxt        = pn_r;
    pret_nxt      = pret_r;
    head_we       = 1'b0;
    head_idx      = k_r;
    head_val      = NIL;
    mem_we        = 1'b0;
    mem_waddr     = i_r;
    mem_wdata     = ENTRY_RESET;
    mem_raddr     = i_r;
    out_valid_nxt = fin;
    out_ok_nxt    = fin_ok;
    out_grant_nxt = '0;
    out_count_nxt = free_r;

    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        clr_nxt   = clr_r + blk_t'(1);
      end
      ST_IDLE: begin
        op_nxt = op_t'(in_op);
        i_nxt  = in_block_offset;
        sz_nxt = in_request_size;
        if (op_t'(in_op) == OP_ALLOC) begin
          sz_nxt = sz_eff;
          kn_nxt = a_k;
          j_nxt  = j_sel;
          i_nxt  = head_r[j_sel][AW-1:0];
        end
      end
      ST_F_CHK: begin
        iw_nxt = mem_q_r;
        if (op_r == OP_SEED) begin
          iw_nxt.ord = log2_of(sz_r);
          k_nxt      = log2_of(sz_r);
        end else begin
          k_nxt = mem_q_r.ord;
        end
      end
      ST_M_TEST: begin
        b_nxt     = b_calc;
        mem_raddr = b_calc;
      end
      ST_M_BQ: begin
        if (buddy_ok) begin
          p_nxt     = mem_q_r.prv;
          n_nxt     = mem_q_r.nxt;
          mem_we    = 1'b1;
          mem_waddr = b_r;
          mem_wdata = '{avail: 1'b0, ord: mem_q_r.ord, nxt: NIL, prv: NIL};
        end
      end
      ST_UNL: begin
        if (link_ok(p_r)) begin
          pa_nxt   = p_r[AW-1:0];
          pv_nxt   = n_r;
          pn_nxt   = 1'b1;
          pret_nxt = ST_UNL2;
        end else begin
          head_we  = 1'b1;
          head_idx = k_r;
          head_val = n_r;
        end
      end
      ST_UNL2: begin
        pa_nxt   = n_r[AW-1:0];
        pv_nxt   = p_r;
        pn_nxt   = 1'b0;
        pret_nxt = ST_M_UPD;
      end
      ST_M_UPD: begin
        k_nxt = k_r + ord_t'(1);
        if (b_r < i_r) begin
          // The lower buddy heads the merged block; the old one keeps its word.
          mem_we    = 1'b1;
          mem_waddr = i_r;
          mem_wdata = iw_r;
          i_nxt     = b_r;
          iw_nxt    = '{avail: 1'b0, ord: k_r + ord_t'(1), nxt: NIL, prv: NIL};
        end else begin
          iw_nxt.ord = k_r + ord_t'(1);
        end
      end
      ST_PUSH: begin
        mem_we    = 1'b1;
        mem_waddr = i_r;
        mem_wdata = '{avail: 1'b1, ord: k_r, nxt: (link_ok(push_h) ? push_h : NIL), prv: NIL};
        head_we   = 1'b1;
        head_idx  = k_r;
        head_val  = {1'b0, i_r};
        pa_nxt    = push_h[AW-1:0];
        pv_nxt    = {1'b0, i_r};
        pn_nxt    = 1'b0;
        pret_nxt  = ST_F_DONE;
        if (!link_ok(push_h)) begin
          free_nxt      = cnt_add;
          out_count_nxt = cnt_add;
        end
      end
      ST_F_DONE: begin
        free_nxt      = cnt_add;
        out_count_nxt = cnt_add;
      end
      ST_A_Q: begin
        head_we   = 1'b1;
        head_idx  = j_r;
        head_val  = link_ok(mem_q_r.nxt) ? mem_q_r.nxt : NIL;
        mem_we    = 1'b1;
        mem_waddr = i_r;
        mem_wdata = '{avail: 1'b0, ord: kn_r, nxt: NIL, prv: NIL};
        pa_nxt    = mem_q_r.nxt[AW-1:0];
        pv_nxt    = NIL;
        pn_nxt    = 1'b0;
        pret_nxt  = ST_SPLIT;
      end
      ST_SPLIT: begin
        if (j_r == kn_r) begin
          free_nxt      = cnt_sub;
          out_count_nxt = cnt_sub;
          out_grant_nxt = i_r;
        end else begin
          // Upper half of the split goes to the head of the next list down.
          j_nxt     = jm;
          mem_we    = 1'b1;
          mem_waddr = c_calc;
          mem_wdata = '{avail: 1'b1, ord: jm, nxt: (link_ok(split_h) ? split_h : NIL), prv: NIL};
          head_we   = 1'b1;
          head_idx  = jm;
          head_val  = {1'b0, c_calc};
          pa_nxt    = split_h[AW-1:0];
          pv_nxt    = {1'b0, c_calc};
          pn_nxt    = 1'b0;
          pret_nxt  = ST_SPLIT;
        end
      end
      ST_P_RD: begin
        mem_raddr = pa_r;
      end
      ST_P_WR: begin
        // A buddy being unlinked keeps the null links it has already been given.
        mem_we    = !((pa_r == b_r) && ((pret_r == ST_UNL2) || (pret_r == ST_M_UPD)));
        mem_waddr = pa_r;
        mem_wdata = mem_q_r;
        if (pn_r) begin
          mem_wdata.nxt = pv_r;
        end else begin
          mem_wdata.prv = pv_r;
        end
        // The held word of the current block follows link updates aimed at it.
        if (pa_r == i_r) begin
          if (pn_r) begin
            iw_nxt.nxt = pv_r;
          end else begin
            iw_nxt.prv = pv_r;
          end
        end
      end
      default: begin
        mem_raddr = i_r;
      end
    endcase
  end

  // Registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      free_r      <= '0;
      max_level_r <= ORD_TOP;
      out_valid_r <= 1'b0;
      for (int h = 0; h < NLISTS; h++) begin
        head_r[h] <= NIL;
      end
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
      if (head_we) begin
        head_r[head_idx] <= head_val;
      end
      if (psel && penable && pwrite && (paddr[2] == REG_MAX_LEVEL)) begin
        max_level_r <= pwdata[OW-1:0];
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    sz_r        <= sz_nxt;
    i_r         <= i_nxt;
    b_r         <= b_nxt;
    k_r         <= k_nxt;
    j_r         <= j_nxt;
    kn_r        <= kn_nxt;
    p_r         <= p_nxt;
    n_r         <= n_nxt;
    iw_r        <= iw_nxt;
    pa_r        <= pa_nxt;
    pv_r        <= pv_nxt;
    pn_r        <= pn_nxt;
    pret_r      <= pret_nxt;
    out_ok_r    <= out_ok_nxt;
    out_grant_r <= out_grant_nxt;
    out_count_r <= out_count_nxt;
  end

  // Ports.
  assign busy              = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_ok            = out_ok_r;
  assign out_granted_block = out_grant_r;
  assign out_free_count    = out_count_r;
  assign pready            = 1'b1;
  assign prdata            = (paddr[2] == REG_MAX_LEVEL) ? {28'd0, max_level_r} : 32'd0;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the buddy block allocator.
`timescale 1ns / 1ps

module tb import bba_pkg::*; ();

  localparam int REGION = 1024;

  // One expected result beat.
  typedef struct {
    logic        ok;
    logic [9:0]  grant;
    logic [10:0] fcount;
  } alloc_res_t;

  // One row of the directed plan; fixed rows carry their expected result.
  typedef struct {
    op_t         op;
    logic [9:0]  off;
    logic [10:0] size;
    bit          fixed;
    alloc_res_t  res;
  } plan_row_t;

  // A block held by the testbench after a granted allocation.
  typedef struct {
    int blk;
    int size;
  } held_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_op;
  logic [9:0]  in_block_offset;
  logic [10:0] in_request_size;
  logic        out_valid;
  logic        out_ok;
  logic [9:0]  out_granted_block;
  logic [10:0] out_free_count;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  buddy_block_allocator DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_block_offset  (in_block_offset),
    .in_request_size  (in_request_size),
    .out_valid        (out_valid),
    .out_ok           (out_ok),
    .out_granted_block(out_granted_block),
    .out_free_count   (out_free_count),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // Shadow copy of the allocator state.
  int         level_cap;
  bit         m_avail [REGION];
  int         m_order [REGION];
  int         m_next  [REGION];
  int         m_prev  [REGION];
  int         m_head  [LOG_BLOCKS+1];
  int         m_free;

  alloc_res_t pending_results[$];
  held_t      held[$];
  int         mismatches;
  int         beats_checked;
  int         items_sent;
  int         grants_seen;
  bit         no_gaps;
  alloc_res_t last_res;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("tb: done, errors");
    $finish;
  end

  function automatic bit is_power(int v);
    return v != 0 && (v & (v - 1)) == 0;
  endfunction

  function automatic int order_of(int v);
    int k;
    k = 0;
    while (v > 1) begin
      v = v >> 1;
      k++;
    end
    return k;
  endfunction

  function automatic int cap_level();
    return level_cap > LOG_BLOCKS ? LOG_BLOCKS : level_cap;
  endfunction

  function automatic void list_push(int i, int k);
    int h;
    h = m_head[k];
    m_avail[i] = 1'b1;
    m_next[i] = h < REGION ? h : REGION;
    m_prev[i] = REGION;
    if (h < REGION) begin
      m_prev[h] = i;
    end
    m_head[k] = i;
  endfunction

  function automatic void list_unlink(int i, int k);
    int p;
    int n;
    p = m_prev[i];
    n = m_next[i];
    if (p < REGION) begin
      m_next[p] = n;
    end else begin
      m_head[k] = n;
    end
    if (n < REGION) begin
      m_prev[n] = p;
    end
    m_next[i] = REGION;
    m_prev[i] = REGION;
    m_avail[i] = 1'b0;
  endfunction

  // Return a block, merging with free buddies of equal order.
  function automatic bit release_block(int i, int count);
    int km;
    int k;
    int b;
    km = cap_level();
    if (m_avail[i]) begin
      return 1'b0;
    end
    forever begin
      k = m_order[i];
      if (k >= km || k >= LOG_BLOCKS) begin
        break;
      end
      b = i ^ (1 << k);
      if (!m_avail[b] || m_order[b] != k) begin
        break;
      end
      list_unlink(b, k);
      if (b < i) begin
        i = b;
      end
      m_order[i] = k + 1;
    end
    k = m_order[i] > LOG_BLOCKS ? LOG_BLOCKS : m_order[i];
    list_push(i, k);
    m_free = m_free + count > REGION ? REGION : m_free + count;
    return 1'b1;
  endfunction

  // Take a block of the requested size, splitting larger ones.
  function automatic bit carve_block(int size, output int grant);
    int km;
    int k;
    int j;
    int i;
    int h;
    int c;
    km = cap_level();
    grant = 0;
    if (size == 0) begin
      size = 1;
    end
    if (!is_power(size)) begin
      return 1'b0;
    end
    k = order_of(size);
    if (k > km) begin
      return 1'b0;
    end
    j = k;
    while (j <= km && m_head[j] >= REGION) begin
      j++;
    end
    if (j > km) begin
      return 1'b0;
    end
    i = m_head[j];
    h = m_next[i];
    m_head[j] = h < REGION ? h : REGION;
    if (h < REGION) begin
      m_prev[h] = REGION;
    end
    m_next[i] = REGION;
    m_prev[i] = REGION;
    m_avail[i] = 1'b0;
    m_order[i] = k;
    while (j > k) begin
      j--;
      c = (i + (1 << j)) & (REGION - 1);
      m_order[c] = j;
      list_push(c, j);
    end
    m_free = m_free > size ? m_free - size : 0;
    grant = i;
    return 1'b1;
  endfunction

  // Work out the result of one command and update the shadow state.
  function automatic alloc_res_t predict_result(op_t op, int off, int size);
    alloc_res_t r;
    int         grant;
    bit         ok;
    grant = 0;
    ok = 1'b0;
    case (op)
      OP_ALLOC: begin
        ok = carve_block(size, grant);
      end
      OP_FREE: begin
        ok = release_block(off, size);
      end
      OP_SEED: begin
        if (is_power(size) && order_of(size) <= LOG_BLOCKS && !m_avail[off]) begin
          m_order[off] = order_of(size);
          ok = release_block(off, size);
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase
    r.ok = ok;
    r.grant = ok ? 10'(grant) : '0;
    r.fcount = 11'(m_free);
    return r;
  endfunction

  // Check each result beat against the oldest expectation.
  always @(posedge clk) begin
    alloc_res_t e;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result beat: ok=%0d grant=%0d free=%0d",
                   out_ok, out_granted_block, out_free_count);
        end
      end else begin
        e = pending_results.pop_front();
        beats_checked++;
        if (out_ok !== e.ok || out_granted_block !== e.grant ||
            out_free_count !== e.fcount) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d mismatch: expected ok=%0d grant=%0d free=%0d,",
                     beats_checked, e.ok, e.grant, e.fcount);
            $display("  got ok=%0d grant=%0d free=%0d",
                     out_ok, out_granted_block, out_free_count);
          end
        end
      end
    end
  end

  // Present one command, wait for it to be taken, then maybe pause.
  task automatic issue(op_t op, logic [9:0] off, logic [10:0] size, bit fixed,
                       alloc_res_t fixed_res);
    alloc_res_t r;
    int         gap;
    @(negedge clk);
    start = 1'b1;
    in_op = op;
    in_block_offset = off;
    in_request_size = size;
    do @(posedge clk); while (busy);
    r = predict_result(op, int'(off), int'(size));
    last_res = r;
    pending_results.push_back(fixed ? fixed_res : r);
    items_sent++;
    if (r.ok && op == OP_ALLOC) begin
      grants_seen++;
    end
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Stop sending and wait until every expected beat has arrived.
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Write max_level once every beat is back and the block is idle.
  task automatic set_level_cap(int value);
    drain();
    repeat (100) @(posedge clk);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = 3'(4 * REG_MAX_LEVEL);
    pwdata = 32'(value);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    level_cap = value & 4'hF;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  function automatic plan_row_t row(op_t op, int off, int size, bit fixed = 1'b0,
                                    bit ok = 1'b0, int grant = 0, int fcount = 0);
    plan_row_t p;
    p.op = op;
    p.off = 10'(off);
    p.size = 11'(size);
    p.fixed = fixed;
    p.res.ok = ok;
    p.res.grant = 10'(grant);
    p.res.fcount = 11'(fcount);
    return p;
  endfunction

  initial begin
    plan_row_t plan[$];
    int        caps[5];
    held_t     h;
    int        pick;
    int        lvl;
    int        sz;
    int        idx;
    op_t       op;

    rst_n = 1'b0;
    start = 1'b0;
    in_op = OP_NONE;
    in_block_offset = '0;
    in_request_size = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mismatches = 0;
    beats_checked = 0;
    items_sent = 0;
    grants_seen = 0;
    no_gaps = 1'b0;
    level_cap = 10;
    m_free = 0;
    for (int i = 0; i < REGION; i++) begin
      m_avail[i] = 1'b0;
      m_order[i] = 0;
      m_next[i] = REGION;
      m_prev[i] = REGION;
    end
    for (int k = 0; k <= LOG_BLOCKS; k++) begin
      m_head[k] = REGION;
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed plan: empty store, bad sizes, seeding, splits, merges, wrap.
    plan.push_back(row(OP_NONE,  0,    0,    1, 0, 0,   0));
    plan.push_back(row(OP_ALLOC, 0,    1,    1, 0, 0,   0));
    plan.push_back(row(OP_SEED,  0,    0,    1, 0, 0,   0));
    plan.push_back(row(OP_SEED,  0,    3,    1, 0, 0,   0));
    plan.push_back(row(OP_SEED,  0,    1024, 1, 1, 0,   1024));
    plan.push_back(row(OP_SEED,  0,    1,    1, 0, 0,   1024));
    plan.push_back(row(OP_FREE,  0,    1024, 1, 0, 0,   1024));
    plan.push_back(row(OP_ALLOC, 0,    0,    1, 1, 0,   1023));
    plan.push_back(row(OP_ALLOC, 0,    3,    1, 0, 0,   1023));
    plan.push_back(row(OP_ALLOC, 0,    1024, 1, 0, 0,   1023));
    plan.push_back(row(OP_ALLOC, 0,    512,  1, 1, 512, 511));
    plan.push_back(row(OP_ALLOC, 0,    1,    1, 1, 1,   510));
    plan.push_back(row(OP_FREE,  512,  512));
    plan.push_back(row(OP_FREE,  1,    1));
    plan.push_back(row(OP_FREE,  0,    1));
    plan.push_back(row(OP_ALLOC, 0,    1024, 1, 1, 0,   0));
    plan.push_back(row(OP_SEED,  1020, 8));
    plan.push_back(row(OP_ALLOC, 0,    4));
    plan.push_back(row(OP_FREE,  1023, 2047));
    plan.push_back(row(OP_FREE,  0,    0));
    plan.push_back(row(OP_ALLOC, 1023, 2047));
    plan.push_back(row(OP_NONE,  1023, 2047));
    plan.push_back(row(OP_SEED,  1023, 1024));
    foreach (plan[i]) begin
      issue(plan[i].op, plan[i].off, plan[i].size, plan[i].fixed, plan[i].res);
    end

    // Random phases, each under its own max_level.
    caps = '{0, 4, 10, 7, 10};
    foreach (caps[p]) begin
      set_level_cap(caps[p]);
      held.delete();
      // Refill: seed a random block of random power-of-two size when nothing is free.
      if (m_free == 0) begin
        issue(OP_SEED, 10'($urandom_range(0, 1023)), 11'(1 << $urandom_range(0, 10)),
              1'b0, last_res);
      end
      for (int n = 0; n < 256; n++) begin
        no_gaps = (n >= 150 && n < 190);
        if (n == 128) begin
          drain();
        end
        pick = $urandom_range(0, 99);
        if (pick < 35 && held.size() != 0) begin
          idx = $urandom_range(0, held.size() - 1);
          h = held[idx];
          held.delete(idx);
          issue(OP_FREE, 10'(h.blk), 11'(h.size), 1'b0, last_res);
        end else if (pick < 88) begin
          lvl = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10) : $urandom_range(0, 2);
          sz = ($urandom_range(0, 30) == 0) ? 0 : (1 << lvl);
          issue(OP_ALLOC, 10'($urandom), 11'(sz), 1'b0, last_res);
          if (last_res.ok) begin
            held.push_back('{blk: int'(last_res.grant), size: sz == 0 ? 1 : sz});
          end
        end else if (pick < 92) begin
          issue(OP_SEED, 10'($urandom_range(0, 1023)), 11'(1 << $urandom_range(0, 10)),
                1'b0, last_res);
        end else begin
          // Noise: any op, any offset, any size.
          op = op_t'($urandom_range(0, 3));
          issue(op, 10'($urandom_range(0, 1023)), 11'($urandom_range(0, 2047)),
                1'b0, last_res);
        end
      end
    end

    // Wind down: all beats back, then room for a late stray beat.
    drain();
    repeat (120) @(posedge clk);
    $display("tb: %0d commands sent, %0d result beats checked, %0d blocks granted",
             items_sent, beats_checked, grants_seen);
    $display("tb: max_level settings 10, 0, 4, 10, 7, 10; %0d mismatches", mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
